@@ design/vwbp_pkg.sv @@
// ----------------------------------------------------------------------------
// vwbp_pkg
// shared constants for the variable width bit packer
// ----------------------------------------------------------------------------
package vwbp_pkg;

    localparam int WORD_BITS_DEF = 32;  // packed word size
    localparam int VALUE_W       = 32;  // input value field
    localparam int WIDTH_W       = 6;   // input width field
    localparam int OUT_W         = 32;  // output word field
    localparam int S_TDATA_W     = 40;  // value + width, padded to bytes
    localparam int M_TDATA_W     = 32;  // word
    localparam int ITEM_Q_DEPTH  = 2;   // front to back queue
    localparam int OUT_Q_DEPTH   = 4;   // result word queue

endpackage

@@ design/variable_width_bit_packer_core.sv @@
// ----------------------------------------------------------------------------
// variable_width_bit_packer_core
// msb-first packer of 1 to 32 bit fields into words
// ----------------------------------------------------------------------------
// Each input transfer carries a value and a field width; the low width bits
// are appended msb first to a pending word, and every filled word goes out
// as one transfer. An input marked with tlast flushes the partial word,
// left-aligned and zero padded, with m_tlast set, so it can give two words.
// The block takes one input transfer per clock cycle, sustained, as long as
// the result side keeps taking words; a finished word passes from the item
// queue through the packing stage, which registers it in the output queue.
// The packing stage works on one item per cycle and waits only when its
// four-word output queue has fewer than two free slots, and the two-entry
// item queue in front lets the input side keep running while the packing
// stage waits.
// ----------------------------------------------------------------------------
module variable_width_bit_packer_core import vwbp_pkg::*; #(
    parameter int WORD_BITS = WORD_BITS_DEF
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,   // value[31:0], width[37:32], zero pad
    input  logic                 s_tlast,   // last_item
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata,   // word[31:0]
    output logic                 m_tlast    // last_word
);

    localparam int W_W    = $clog2(WORD_BITS + 1);
    localparam int ITEM_W = WORD_BITS + W_W + 1;

    logic [WORD_BITS-1:0] f_value, b_value;
    logic [W_W-1:0]       f_width, b_width;
    logic                 f_last, b_last;
    logic [ITEM_W-1:0]    q_rd_data;
    logic                 q_rd_valid, q_rd_ready;

    vwbp_front #(
        .WORD_BITS (WORD_BITS),
        .W_W       (W_W)
    ) u_front (
        .s_tdata    (s_tdata),
        .s_tlast    (s_tlast),
        .item_value (f_value),
        .item_width (f_width),
        .item_last  (f_last)
    );

    vwbp_fifo #(
        .WIDTH (ITEM_W),
        .DEPTH (ITEM_Q_DEPTH)
    ) u_item_q (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .wr_valid (s_tvalid),
        .wr_ready (s_tready),
        .wr_data  ({f_last, f_width, f_value}),
        .rd_valid (q_rd_valid),
        .rd_ready (q_rd_ready),
        .rd_data  (q_rd_data)
    );

    assign b_value = q_rd_data[WORD_BITS-1:0];
    assign b_width = q_rd_data[WORD_BITS +: W_W];
    assign b_last  = q_rd_data[ITEM_W-1];

    vwbp_back #(
        .WORD_BITS (WORD_BITS),
        .W_W       (W_W)
    ) u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .item_valid (q_rd_valid),
        .item_ready (q_rd_ready),
        .item_value (b_value),
        .item_width (b_width),
        .item_last  (b_last),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tlast    (m_tlast)
    );

endmodule

@@ design/vwbp_front.sv @@
// ----------------------------------------------------------------------------
// vwbp_front
// unpacks an input transfer, saturates the field width and masks the value
// ----------------------------------------------------------------------------
module vwbp_front import vwbp_pkg::*; #(
    parameter int WORD_BITS = WORD_BITS_DEF,
    parameter int W_W       = $clog2(WORD_BITS + 1)
) (
    input  logic [S_TDATA_W-1:0] s_tdata,    // value[31:0], width[37:32], zero pad
    input  logic                 s_tlast,    // last_item
    output logic [WORD_BITS-1:0] item_value,
    output logic [W_W-1:0]       item_width,
    output logic                 item_last
);

    logic [VALUE_W-1:0] value_in;
    logic [WIDTH_W-1:0] width_in;
    logic [VALUE_W-1:0] value_masked;

    assign value_in = s_tdata[VALUE_W-1:0];
    assign width_in = s_tdata[VALUE_W +: WIDTH_W];

    // widths beyond the word size act as a full word
    always_comb begin
        if (32'(width_in) > 32'(WORD_BITS)) begin
            item_width = W_W'(WORD_BITS);
        end else begin
            item_width = W_W'(width_in);
        end
    end

    // shift of 32 or more clears the shifted ones, so the mask becomes all ones
    assign value_masked = value_in & ~({VALUE_W{1'b1}} << item_width);
    assign item_value   = WORD_BITS'(value_masked);
    assign item_last    = s_tlast;

endmodule

@@ design/vwbp_fifo.sv @@
// ----------------------------------------------------------------------------
// vwbp_fifo
// small register queue between the front and the back
// ----------------------------------------------------------------------------
module vwbp_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             wr_valid,
    output logic             wr_ready,
    input  logic [WIDTH-1:0] wr_data,
    output logic             rd_valid,
    input  logic             rd_ready,
    output logic [WIDTH-1:0] rd_data
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             push, pop;

    assign wr_ready = (count_reg != CNT_W'(DEPTH));
    assign rd_valid = (count_reg != '0);
    assign rd_data  = mem_reg[rd_ptr_reg];
    assign push     = wr_valid && wr_ready;
    assign pop      = rd_valid && rd_ready;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        count_next = count_reg + CNT_W'(push) - CNT_W'(pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

@@ design/vwbp_back.sv @@
// ----------------------------------------------------------------------------
// vwbp_back
// appends fields to the pending word and queues the finished words
// ----------------------------------------------------------------------------
module vwbp_back import vwbp_pkg::*; #(
    parameter int WORD_BITS = WORD_BITS_DEF,
    parameter int W_W       = $clog2(WORD_BITS + 1)
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 item_valid,
    output logic                 item_ready,
    input  logic [WORD_BITS-1:0] item_value,
    input  logic [W_W-1:0]       item_width,
    input  logic                 item_last,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata,
    output logic                 m_tlast
);

    localparam int CNT_W  = $clog2(WORD_BITS);
    localparam int T_W    = CNT_W + 1;
    localparam int SH_W   = $clog2(2 * WORD_BITS + 1);
    localparam int OQ_PW  = $clog2(OUT_Q_DEPTH);
    localparam int OQ_CW  = $clog2(OUT_Q_DEPTH + 1);

    logic [WORD_BITS-1:0]   pending_reg, pending_next;
    logic [CNT_W-1:0]       bit_cnt_reg, bit_cnt_next;
    logic [T_W-1:0]         total;
    logic [SH_W-1:0]        shamt;
    logic [2*WORD_BITS-1:0] acc;
    logic [WORD_BITS-1:0]   acc_hi, acc_lo;
    logic                   over, rem_zero, take;
    logic                   push0, push1, last0;

    logic [OUT_W-1:0]       oq_word_reg [OUT_Q_DEPTH];
    logic                   oq_last_reg [OUT_Q_DEPTH];
    logic [OQ_PW-1:0]       oq_wr_reg, oq_wr_next, oq_wr_plus1;
    logic [OQ_PW-1:0]       oq_rd_reg, oq_rd_next;
    logic [OQ_CW-1:0]       oq_cnt_reg, oq_cnt_next;
    logic                   out_pop;

    // output side of the word queue
    assign m_tvalid = (oq_cnt_reg != '0);
    assign m_tdata  = oq_word_reg[oq_rd_reg];
    assign m_tlast  = oq_last_reg[oq_rd_reg];
    assign out_pop  = m_tvalid && m_tready;

    // an item may produce two words, so keep two slots free
    assign item_ready = ((oq_cnt_reg - OQ_CW'(out_pop)) <= OQ_CW'(OUT_Q_DEPTH - 2));
    assign take       = item_valid && item_ready;

    // place the field just below the pending bits in a double-width window
    assign total    = T_W'(bit_cnt_reg) + T_W'(item_width);
    assign shamt    = SH_W'(2 * WORD_BITS) - SH_W'(total);
    assign acc      = {pending_reg, {WORD_BITS{1'b0}}}
                    | ((2 * WORD_BITS)'(item_value) << shamt);
    assign acc_hi   = acc[2*WORD_BITS-1:WORD_BITS];
    assign acc_lo   = acc[WORD_BITS-1:0];
    assign over     = (total >= T_W'(WORD_BITS));
    assign rem_zero = (total == T_W'(WORD_BITS));

    assign push0 = take && (over || item_last);
    assign push1 = take && item_last && over && !rem_zero;
    assign last0 = over ? (item_last && rem_zero) : item_last;

    always_comb begin
        pending_next = pending_reg;
        bit_cnt_next = bit_cnt_reg;
        if (take) begin
            if (item_last) begin
                pending_next = '0;
                bit_cnt_next = '0;
            end else if (over) begin
                pending_next = acc_lo;
                bit_cnt_next = CNT_W'(total - T_W'(WORD_BITS));
            end else begin
                pending_next = acc_hi;
                bit_cnt_next = CNT_W'(total);
            end
        end
    end

    always_comb begin
        oq_wr_plus1 = oq_wr_reg + 1'b1;
        oq_wr_next  = oq_wr_reg + OQ_PW'(push0) + OQ_PW'(push1);
        oq_rd_next  = oq_rd_reg + OQ_PW'(out_pop);
        oq_cnt_next = oq_cnt_reg + OQ_CW'(push0) + OQ_CW'(push1) - OQ_CW'(out_pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pending_reg <= '0;
            bit_cnt_reg <= '0;
            oq_wr_reg   <= '0;
            oq_rd_reg   <= '0;
            oq_cnt_reg  <= '0;
        end else begin
            pending_reg <= pending_next;
            bit_cnt_reg <= bit_cnt_next;
            oq_wr_reg   <= oq_wr_next;
            oq_rd_reg   <= oq_rd_next;
            oq_cnt_reg  <= oq_cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push0) begin
            oq_word_reg[oq_wr_reg] <= OUT_W'(acc_hi);
            oq_last_reg[oq_wr_reg] <= last0;
        end
        if (push1) begin
            oq_word_reg[oq_wr_plus1] <= OUT_W'(acc_lo);
            oq_last_reg[oq_wr_plus1] <= 1'b1;
        end
    end

endmodule

@@ design/vwbp_checker.sv @@
// ----------------------------------------------------------------------------
// vwbp_checker
// port-level checks for the bit packer, bound to the top level
// ----------------------------------------------------------------------------
module vwbp_checker import vwbp_pkg::*; (
    input logic                 aclk,
    input logic                 aresetn,
    input logic                 s_tvalid,
    input logic                 s_tready,
    input logic                 s_tlast,
    input logic                 m_tvalid,
    input logic                 m_tready,
    input logic [M_TDATA_W-1:0] m_tdata,
    input logic                 m_tlast
);

    logic [3:0] open_frames_reg;
    logic       s_last_xfer, m_last_xfer;

    assign s_last_xfer = s_tvalid && s_tready && s_tlast;
    assign m_last_xfer = m_tvalid && m_tready && m_tlast;

    // frames whose closing input has been taken but whose final word is still due
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            open_frames_reg <= '0;
        end else begin
            open_frames_reg <= open_frames_reg + 4'(s_last_xfer) - 4'(m_last_xfer);
        end
    end

    // a stalled word holds until it is taken
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("output word changed while stalled");

    // a final word needs a closing input transfer before it
    a_last_has_cause: assert property (@(posedge aclk) disable iff (!aresetn)
        m_last_xfer |-> open_frames_reg != '0)
        else $error("final word without a closing input");

    // nothing is offered right after reset
    a_reset_quiet: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("output valid right after reset");

    // no final word is taken while no closing input transfer is outstanding
    a_frame_balance: assert property (@(posedge aclk) disable iff (!aresetn)
        open_frames_reg == '0 |-> !m_last_xfer)
        else $error("more final words than closing inputs");

endmodule

bind variable_width_bit_packer_core vwbp_checker u_vwbp_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
);
